/* sv/grlp_pkg.sv */
`default_nettype none

package grlp_pkg;

   // Special bytes of the serial protocol.
   localparam logic [7:0] BYTE_ACK   = 8'h06;
   localparam logic [7:0] BYTE_NACK  = 8'h15;
   localparam logic [7:0] BYTE_LF    = 8'h0A;
   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_NUL   = 8'h00;
   localparam logic [7:0] BYTE_M     = 8'h4D;

   // Upper nibble shared by the ASCII digits.
   localparam logic [3:0] DIGIT_HIGH = 4'h3;
   localparam logic [3:0] DIGIT_MAX  = 4'd9;

   // Kind of a result word.
   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_EOL     = 2'd1,
      KIND_NACK    = 2'd2
   } kind_type;

   // One result word.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [15:0] command_number;
      logic        unexpected_start;
      logic        last;
   } result_type;

endpackage

`default_nettype wire

/* sv/grlp_if.sv */
`default_nettype none

// Channel that carries received bytes.
interface grlp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// Channel that carries parsed result words.
interface grlp_rsp_if;
   import grlp_pkg::*;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  data_byte;
   logic [15:0] command_number;
   logic        unexpected_start;
   logic        last;

   modport source (output valid, output kind, output data_byte, output command_number,
                   output unexpected_start, output last, input ready);
   modport sink   (input valid, input kind, input data_byte, input command_number,
                   input unexpected_start, input last, output ready);
endinterface

`default_nettype wire

/* sv/grlp_parse_core.sv */
`default_nettype none

module grlp_parse_core
   import grlp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] rx_byte,
   output logic            res_valid,
   output result_type      res
);

   logic        in_payload_ff, in_payload_in;
   logic        line_nonempty_ff, line_nonempty_in;
   logic [15:0] acc_ff, acc_in;
   logic        not_m_ff, not_m_in;

   logic        is_digit;
   logic [15:0] acc_times_ten;

   // Digit test and the next decimal accumulation, wrapping at 16 bits.
   assign is_digit      = (rx_byte[7:4] == DIGIT_HIGH) && (rx_byte[3:0] <= DIGIT_MAX);
   assign acc_times_ten = {acc_ff[12:0], 3'b000} + {acc_ff[14:0], 1'b0}
                        + {12'd0, rx_byte[3:0]};

   // Classify the byte and work out the result and the next line state.
   always_comb begin
      in_payload_in    = in_payload_ff;
      line_nonempty_in = line_nonempty_ff;
      acc_in           = acc_ff;
      not_m_in         = not_m_ff;
      res_valid        = 1'b0;
      res              = '0;
      priority if (rx_byte == BYTE_CR || rx_byte == BYTE_LF) begin
         if (line_nonempty_ff) begin
            res_valid            = 1'b1;
            res.kind             = KIND_EOL;
            res.command_number   = acc_ff;
            res.unexpected_start = not_m_ff;
            res.last             = 1'b1;
            in_payload_in        = 1'b0;
            line_nonempty_in     = 1'b0;
            acc_in               = '0;
            not_m_in             = 1'b0;
         end
      end else if (rx_byte == BYTE_ACK) begin
         res_valid = 1'b0;
      end else if (rx_byte == BYTE_NACK) begin
         res_valid = 1'b1;
         res.kind  = KIND_NACK;
      end else begin
         // A stored byte: the first one of the line decides the start flag.
         if (!line_nonempty_ff) begin
            line_nonempty_in = 1'b1;
            not_m_in         = (rx_byte != BYTE_M);
         end
         priority if (in_payload_ff) begin
            res_valid     = 1'b1;
            res.kind      = KIND_PAYLOAD;
            res.data_byte = rx_byte;
         end else if (rx_byte == BYTE_SPACE) begin
            in_payload_in = 1'b1;
         end else if (rx_byte == BYTE_NUL) begin
            in_payload_in = 1'b1;
            res_valid     = 1'b1;
            res.kind      = KIND_PAYLOAD;
            res.data_byte = rx_byte;
         end else if (is_digit) begin
            acc_in = acc_times_ten;
         end else begin
            acc_in = acc_ff;
         end
      end
   end

   // Line state registers advance once per processed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff    <= 1'b0;
         line_nonempty_ff <= 1'b0;
         acc_ff           <= '0;
         not_m_ff         <= 1'b0;
      end else if (step) begin
         in_payload_ff    <= in_payload_in;
         line_nonempty_ff <= line_nonempty_in;
         acc_ff           <= acc_in;
         not_m_ff         <= not_m_in;
      end
   end

   // An empty line holds no number, no start flag and is still in its first token.
   a_empty_line_clear: assert property (@(posedge clock) disable iff (reset)
      !line_nonempty_ff |-> (acc_ff == '0) && !not_m_ff && !in_payload_ff)
      else $error("empty line carries leftover state");

   // A line end that produces a result returns the state to zero.
   a_eol_clears: assert property (@(posedge clock) disable iff (reset)
      step && res_valid && (res.kind == KIND_EOL) |=> !line_nonempty_ff && (acc_ff == '0))
      else $error("state not cleared after end of line");

   // Only an end-of-line word carries the last mark.
   a_last_only_eol: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (res.last == (res.kind == KIND_EOL)))
      else $error("last mark on a word that is not an end of line");

endmodule

`default_nettype wire

/* sv/gcode_response_line_parser_unit.sv */
// Channel   Direction  Modport          Contents
// req_if    in         grlp_req_if.sink   one received byte per word
// rsp_if    out        grlp_rsp_if.source payload byte, end of line or nack
//
// One byte is accepted per clock cycle while req_if.ready is high. Its result
// word passes through the input register and then the result register before
// it is presented on rsp_if. Bytes that give no result (ACK, empty line
// ends, first-token bytes) are consumed without a word. Reset is synchronous
// and clears all line state. While the result register is stalled, one more
// byte waits in the input register before req_if.ready drops.
`default_nettype none

module gcode_response_line_parser_unit
   import grlp_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   grlp_req_if.sink   req_if,
   grlp_rsp_if.source rsp_if
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff;

   logic       out_free;
   logic       step;
   logic       res_valid;
   result_type res;

   // The result register can take a word when empty or being drained.
   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign step         = in_valid_ff && out_free;
   assign req_if.ready = !in_valid_ff || out_free;

   grlp_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_byte   (in_byte_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // Valid bits of the two registers.
   always_comb begin
      if (req_if.valid && req_if.ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (step && res_valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_byte_ff <= req_if.rx_byte;
      end
      if (step && res_valid) begin
         out_res_ff <= res;
      end
   end

   assign rsp_if.valid            = out_valid_ff;
   assign rsp_if.kind             = out_res_ff.kind;
   assign rsp_if.data_byte        = out_res_ff.data_byte;
   assign rsp_if.command_number   = out_res_ff.command_number;
   assign rsp_if.unexpected_start = out_res_ff.unexpected_start;
   assign rsp_if.last             = out_res_ff.last;

   // The input side stalls only when a byte is held.
   a_ready_low_held: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> in_valid_ff)
      else $error("input stalled with empty input register");

   // A held byte waits only behind a full, stalled result register.
   a_hold_reason: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |-> out_valid_ff && !rsp_if.ready)
      else $error("byte held without a stalled result");

   // A produced word is always presented in the next cycle.
   a_word_shown: assert property (@(posedge clock) disable iff (reset)
      step && res_valid |=> rsp_if.valid)
      else $error("produced word not presented");

endmodule

`default_nettype wire

/* test/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import grlp_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned RANDOM_BYTES = 650;
   localparam int unsigned LONG_HOLD = 60;
   localparam int unsigned SETTLE_CYCLES = 10;

   // One byte waiting to be sent, with the idle cycles before it.
   typedef struct {
      logic [7:0]  value;
      int unsigned gap;
      bit          drain;
   } pending_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   grlp_req_if req_ch ();
   grlp_rsp_if rsp_ch ();

   gcode_response_line_parser_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   pending_byte_type pending_bytes[$];
   result_type       expected_words[$];

   // Line state of the predictor.
   bit          body_started;
   bit          line_started;
   logic [15:0] cmd_acc;
   bit          line_not_m;

   int unsigned error_count = 0;
   int unsigned bytes_sent;
   int unsigned words_seen;
   int unsigned gap_left;
   int unsigned stall_left;
   int unsigned hold_left;
   bit          hold_done;
   int unsigned hold_at;
   int unsigned cycle_count = 0;
   bit          calm_tx;
   bit          drain_next;

   // Clock and reset.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.rx_byte = 8'h00;
      rsp_ch.ready = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Predicts the word caused by one received byte; returns 1 if there is one.
   function automatic bit parse_byte(input logic [7:0] b, output result_type w);
      w = '0;
      w.kind = KIND_PAYLOAD;
      if (b == BYTE_CR || b == BYTE_LF) begin
         if (!line_started) return 1'b0;
         w.kind = KIND_EOL;
         w.command_number = cmd_acc;
         w.unexpected_start = line_not_m;
         w.last = 1'b1;
         body_started = 1'b0;
         line_started = 1'b0;
         cmd_acc = '0;
         line_not_m = 1'b0;
         return 1'b1;
      end
      if (b == BYTE_ACK) return 1'b0;
      if (b == BYTE_NACK) begin
         w.kind = KIND_NACK;
         return 1'b1;
      end
      // Any other byte is stored in the line.
      if (!line_started) begin
         line_started = 1'b1;
         line_not_m = (b != BYTE_M);
      end
      if (body_started) begin
         w.data_byte = b;
         return 1'b1;
      end
      if (b == BYTE_SPACE) begin
         body_started = 1'b1;
         return 1'b0;
      end
      if (b == BYTE_NUL) begin
         body_started = 1'b1;
         w.data_byte = b;
         return 1'b1;
      end
      if (b[7:4] == DIGIT_HIGH && b[3:0] <= DIGIT_MAX)
         cmd_acc = 16'((32'(cmd_acc) * 10) + 32'(b[3:0]));
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      error_count++;
      $display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
   endtask

   task automatic add_byte(input logic [7:0] b);
      pending_bytes.push_back('{value: b, gap: calm_tx ? 0 : $urandom_range(0, 9),
                                drain: drain_next});
      drain_next = 1'b0;
   endtask

   task automatic add_text(input string s);
      foreach (s[i]) add_byte(s[i]);
   endtask

   // One random response line: a first token, an optional separator, a body and an end.
   task automatic add_random_line();
      int unsigned lead;
      int unsigned n;
      lead = $urandom_range(0, 9);
      if (lead < 6) add_byte(BYTE_M);
      else if (lead < 8) add_text("G");
      else if (lead == 9) add_byte(8'($urandom_range(0, 255)));
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 4);
      repeat (n) begin
         if ($urandom_range(0, 15) == 0) add_byte(8'($urandom_range(0, 255)));
         else add_byte(8'($urandom_range(8'h30, 8'h39)));
      end
      case ($urandom_range(0, 5))
         0: add_byte(BYTE_NUL);
         1: ;
         default: add_byte(BYTE_SPACE);
      endcase
      n = $urandom_range(0, 12);
      repeat (n) begin
         case ($urandom_range(0, 19))
            0: add_byte(BYTE_ACK);
            1: add_byte(BYTE_NACK);
            2, 3: add_byte(8'($urandom_range(0, 255)));
            default: add_byte(8'($urandom_range(8'h21, 8'h7E)));
         endcase
      end
      case ($urandom_range(0, 2))
         0: add_byte(BYTE_CR);
         1: add_byte(BYTE_LF);
         default: begin
            add_byte(BYTE_CR);
            add_byte(BYTE_LF);
         end
      endcase
   endtask

   // Fill the byte queue, then wait for the run to drain.
   initial begin
      int unsigned line_no;
      body_started = 1'b0;
      line_started = 1'b0;
      cmd_acc = '0;
      line_not_m = 1'b0;
      calm_tx = 1'b0;
      drain_next = 1'b0;

      // Directed: ACK, NACK and an empty line.
      add_byte(BYTE_ACK);
      add_byte(BYTE_NACK);
      add_byte(BYTE_LF);
      // An ordinary M line.
      add_text("M7 A");
      add_byte(BYTE_CR);
      // Number overflow, NUL ending the token, top byte value, non-M start.
      add_text("G99999");
      add_byte(BYTE_NUL);
      add_byte(8'hFF);
      add_byte(BYTE_LF);
      // Non-digit in the token, ACK and NACK inside a line, CR LF ending.
      add_text("Mx");
      add_byte(BYTE_ACK);
      add_byte(BYTE_NACK);
      add_byte(BYTE_CR);
      add_byte(BYTE_LF);

      // Back-to-back body bytes while the receiver holds off for a long time.
      drain_next = 1'b1;
      calm_tx = 1'b1;
      hold_at = pending_bytes.size() + 3;
      add_text("M5 ");
      repeat (40) add_byte(8'($urandom_range(8'h21, 8'h7E)));
      add_byte(BYTE_LF);
      calm_tx = 1'b0;

      line_no = 0;
      while (pending_bytes.size() < RANDOM_BYTES) begin
         calm_tx = (line_no % 12) < 2;
         if (line_no % 15 == 7) drain_next = 1'b1;
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(0, 255)));
         end else begin
            add_random_line();
         end
         line_no++;
      end

      @(posedge clock);
      while (reset || pending_bytes.size() > 0 || req_ch.valid) @(posedge clock);
      while (expected_words.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Byte driver; predicts each word as its byte is accepted.
   always @(posedge clock) begin : drive_bytes
      result_type       word;
      pending_byte_type head;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.rx_byte <= 8'h00;
         gap_left <= 0;
         bytes_sent <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            bytes_sent <= bytes_sent + 1;
            if (parse_byte(req_ch.rx_byte, word)) expected_words.push_back(word);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               req_ch.valid <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (pending_bytes.size() > 0 &&
                         !(pending_bytes[0].drain && expected_words.size() > 0)) begin
               head = pending_bytes.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.rx_byte <= head.value;
               if (pending_bytes.size() > 0) gap_left <= pending_bytes[0].gap;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, started once the burst line's token is in.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && bytes_sent == hold_at) begin
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end
   end

   // Word monitor: compares each accepted word with the oldest prediction.
   always @(posedge clock) begin : check_words
      result_type  want;
      int unsigned wait_cycles;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= 0;
         words_seen <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            words_seen <= words_seen + 1;
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word, kind", 16'(rsp_ch.kind), 16'hFFFF);
            end else begin
               want = expected_words.pop_front();
               if (rsp_ch.kind !== want.kind)
                  report_mismatch("kind", 16'(rsp_ch.kind), 16'(want.kind));
               if (rsp_ch.data_byte !== want.data_byte)
                  report_mismatch("data_byte", 16'(rsp_ch.data_byte), 16'(want.data_byte));
               if (rsp_ch.command_number !== want.command_number)
                  report_mismatch("command_number", rsp_ch.command_number,
                                  want.command_number);
               if (rsp_ch.unexpected_start !== want.unexpected_start)
                  report_mismatch("unexpected_start", 16'(rsp_ch.unexpected_start),
                                  16'(want.unexpected_start));
               if (rsp_ch.last !== want.last)
                  report_mismatch("last", 16'(rsp_ch.last), 16'(want.last));
            end
            // Some stretches of words are taken without any stall.
            wait_cycles = ((words_seen / 40) % 3 == 1) ? 0 : $urandom_range(0, 9);
            stall_left <= wait_cycles;
            rsp_ch.ready <= (wait_cycles == 0) && (hold_left == 0);
         end else if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule
